// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files of the expression evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define IEE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("iee assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define IEE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("iee forbidden condition seen");
`else
`define IEE_ASSERT(lbl, clk, rstn, prop)
`define IEE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- src/iee_pkg.sv -----
// Types and constants shared by the expression evaluator modules.
package iee_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned RESULT_WIDTH    = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] RADIX      = 8'd10;
  localparam logic [7:0] CHAR_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SUB   = 8'h2D;  // '-'

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIGIT,
    OP_MUL,
    OP_DIV,
    OP_ADD,
    OP_SUB
  } op_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_MUL  = 2'd1,
    PEND_DIV  = 2'd2
  } pend_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_POST
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] digit;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } md_stat_t;

endpackage

// ----- src/iee_front.sv -----
// Front end: classifies each character into a token for the queue.
module iee_front (
  input  logic          push_i,
  input  logic [7:0]    char_code_i,
  input  logic          last_i,
  input  logic          q_full_i,
  output logic          full_o,
  output logic          wr_o,
  output iee_pkg::tok_t tok_o
);
  import iee_pkg::*;

  logic [7:0] offs;
  logic       keep;

  assign offs = char_code_i - CHAR_ZERO;

  always_comb begin
    tok_o.digit = offs[3:0];
    tok_o.last  = last_i;
    priority if (offs < RADIX) begin
      tok_o.op = OP_DIGIT;
    end else if (char_code_i == CHAR_MUL) begin
      tok_o.op = OP_MUL;
    end else if (char_code_i == CHAR_DIV) begin
      tok_o.op = OP_DIV;
    end else if (char_code_i == CHAR_ADD) begin
      tok_o.op = OP_ADD;
    end else if (char_code_i == CHAR_SUB) begin
      tok_o.op = OP_SUB;
    end else begin
      tok_o.op = OP_NONE;
    end
  end

  // other characters are dropped unless they close the expression
  assign keep   = (tok_o.op != OP_NONE) || last_i;
  assign full_o = q_full_i;
  assign wr_o   = push_i && !q_full_i && keep;

endmodule

// ----- src/iee_fifo.sv -----
// Short token queue between front and back end.
module iee_fifo #(
  parameter int unsigned DEPTH = iee_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  iee_pkg::tok_t wdata_i,
  input  logic          rd_i,
  output iee_pkg::tok_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import iee_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tok_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      count_d = count_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);

  `IEE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `IEE_ASSERT_NEVER(a_no_read_empty, clk_i, rst_ni, rd_i && (count_q == '0))

endmodule

// ----- src/iee_muldiv.sv -----
// Iterative shift-add multiplier and restoring signed divider, one bit per cycle.
module iee_muldiv #(
  parameter int unsigned VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  iee_pkg::md_ctrl_t      ctrl_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output logic [VALUE_WIDTH-1:0] res_o,
  output iee_pkg::md_stat_t      stat_o
);
  import iee_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          is_div_q, is_div_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  x_q, x_d, y_q, y_d, acc_q, acc_d, res_q, res_d;
  logic          done_q, done_d, dz_q, dz_d;

  logic [W-1:0]  abs_a, abs_b;
  logic [W:0]    trial;
  logic          ge;
  logic [W:0]    diff;

  assign abs_a = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign abs_b = b_i[W-1] ? (~b_i + 1'b1) : b_i;
  assign trial = {acc_q, x_q[W-1]};
  assign diff  = trial - {1'b0, y_q};
  assign ge    = !diff[W];

  always_comb begin
    busy_d   = busy_q;
    is_div_d = is_div_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    x_d      = x_q;
    y_d      = y_q;
    acc_d    = acc_q;
    res_d    = res_q;
    done_d   = 1'b0;
    dz_d     = 1'b0;
    if (ctrl_i.start) begin
      is_div_d = ctrl_i.is_div;
      acc_d    = '0;
      cnt_d    = '0;
      if (ctrl_i.is_div) begin
        x_d   = abs_a;
        y_d   = abs_b;
        neg_d = a_i[W-1] ^ b_i[W-1];
        if (abs_b == '0) begin
          // quotient 0 and the error flag, no iterations
          res_d  = '0;
          done_d = 1'b1;
          dz_d   = 1'b1;
        end else begin
          busy_d = 1'b1;
        end
      end else begin
        x_d    = b_i;
        y_d    = a_i;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (is_div_q) begin
        acc_d = ge ? diff[W-1:0] : trial[W-1:0];
        x_d   = {x_q[W-2:0], ge};
      end else begin
        acc_d = x_q[0] ? (acc_q + y_q) : acc_q;
        x_d   = x_q >> 1;
        y_d   = y_q << 1;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (is_div_q) begin
          res_d = neg_q ? (~x_d + 1'b1) : x_d;
        end else begin
          res_d = acc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dz_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      dz_q   <= dz_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_div_q <= is_div_d;
    neg_q    <= neg_d;
    x_q      <= x_d;
    y_q      <= y_d;
    acc_q    <= acc_d;
    res_q    <= res_d;
  end

  assign res_o           = res_q;
  assign stat_o.done     = done_q;
  assign stat_o.div_zero = dz_q;

  `IEE_ASSERT_NEVER(a_start_idle, clk_i, rst_ni, ctrl_i.start && (busy_q || done_q))

endmodule

// ----- src/iee_back.sv -----
// Back end: sequencer that folds tokens into operand, term and sum, and holds the result.
module iee_back #(
  parameter int unsigned VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  iee_pkg::tok_t          tok_i,
  input  logic                   tok_empty_i,
  output logic                   tok_pop_o,
  output iee_pkg::md_ctrl_t      md_ctrl_o,
  output logic [VALUE_WIDTH-1:0] md_a_o,
  output logic [VALUE_WIDTH-1:0] md_b_o,
  input  logic [VALUE_WIDTH-1:0] md_res_i,
  input  iee_pkg::md_stat_t      md_stat_i,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic signed [iee_pkg::RESULT_WIDTH-1:0] value_o,
  output logic                   div_by_zero_o
);
  import iee_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned W = VALUE_WIDTH;

  state_e       state_q, state_d;
  op_e          op_q, op_d;
  logic         last_q, last_d;
  logic [W-1:0] num_q, num_d, term_q, term_d, sum_q, sum_d;
  pend_e        pend_q, pend_d;
  logic         sub_q, sub_d, err_q, err_d;
  logic         out_valid_q, out_valid_d;
  logic [RESULT_WIDTH-1:0] out_value_q, out_value_d;
  logic         out_dz_q, out_dz_d;

  logic [W-1:0]  fin_sum;
  logic [63:0]   fin_wide;

  assign fin_sum  = sub_q ? (sum_q - term_q) : (sum_q + term_q);
  assign fin_wide = 64'($signed(fin_sum));

  assign md_a_o = term_q;
  assign md_b_o = num_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    last_d      = last_q;
    num_d       = num_q;
    term_d      = term_q;
    sum_d       = sum_q;
    pend_d      = pend_q;
    sub_d       = sub_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_dz_d    = out_dz_q;
    tok_pop_o   = 1'b0;
    md_ctrl_o   = '0;

    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!tok_empty_i) begin
          tok_pop_o = 1'b1;
          if (tok_i.op == OP_DIGIT) begin
            num_d = (num_q << 3) + (num_q << 1) + W'(tok_i.digit);
            if (tok_i.last) begin
              op_d    = OP_NONE;
              last_d  = 1'b0;
              state_d = ST_EXEC;
            end
          end else begin
            op_d    = tok_i.op;
            last_d  = tok_i.last;
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        // fold the operand into the term
        if (pend_q == PEND_MUL || pend_q == PEND_DIV) begin
          md_ctrl_o.start  = 1'b1;
          md_ctrl_o.is_div = (pend_q == PEND_DIV);
          state_d          = ST_WAIT;
        end else begin
          term_d  = num_q;
          num_d   = '0;
          state_d = ST_POST;
        end
      end
      ST_WAIT: begin
        if (md_stat_i.done) begin
          term_d  = md_res_i;
          err_d   = err_q | md_stat_i.div_zero;
          num_d   = '0;
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        if (op_q == OP_NONE) begin
          // closing fold: hand the sum over once the result slot is free
          if (!out_valid_q || pop_i) begin
            out_valid_d = 1'b1;
            out_value_d = fin_wide[RESULT_WIDTH-1:0];
            out_dz_d    = err_q;
            num_d       = '0;
            term_d      = '0;
            sum_d       = '0;
            pend_d      = PEND_NONE;
            sub_d       = 1'b0;
            err_d       = 1'b0;
            state_d     = ST_IDLE;
          end
        end else begin
          unique case (op_q)
            OP_MUL: pend_d = PEND_MUL;
            OP_DIV: pend_d = PEND_DIV;
            OP_ADD, OP_SUB: begin
              sum_d  = fin_sum;
              term_d = '0;
              pend_d = PEND_NONE;
              sub_d  = (op_q == OP_SUB);
            end
            default: pend_d = pend_q;
          endcase
          if (last_q) begin
            op_d    = OP_NONE;
            last_d  = 1'b0;
            state_d = ST_EXEC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      last_q      <= 1'b0;
      num_q       <= '0;
      term_q      <= '0;
      sum_q       <= '0;
      pend_q      <= PEND_NONE;
      sub_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      last_q      <= last_d;
      num_q       <= num_d;
      term_q      <= term_d;
      sum_q       <= sum_d;
      pend_q      <= pend_d;
      sub_q       <= sub_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_dz_q    <= out_dz_d;
  end

  assign empty_o       = !out_valid_q;
  assign value_o       = $signed(out_value_q);
  assign div_by_zero_o = out_dz_q;

  `IEE_ASSERT(a_done_in_wait, clk_i, rst_ni, md_stat_i.done |-> (state_q == ST_WAIT))

endmodule

// ----- src/infix_expression_evaluator.sv -----
// Streaming infix integer expression evaluator, top level.
// A digit is folded into the operand directly; an operator passes through the fold and
// post steps, waiting on the multiply/divide unit when a multiply or divide is pending;
// a closing operator folds twice. Throughput is set by the bit-serial multiply/divide
// unit; the back end takes the next token only once it is back in idle.
// Reset (rst_ni low, asynchronous) empties the queues and clears the back end's evaluation state.
module infix_expression_evaluator #(
  parameter int unsigned VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = iee_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character input, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code_i,
  input  logic        last_i,
  // result output, queue style
  output logic        empty,
  input  logic        pop,
  output logic signed [iee_pkg::RESULT_WIDTH-1:0] value_o,
  output logic        div_by_zero_o
);
  import iee_pkg::*;

  // front end to token queue
  logic     q_wr, q_full, q_empty, q_rd;
  tok_t     q_wdata, q_rdata;

  // back end to multiply/divide unit
  md_ctrl_t                 md_ctrl;
  md_stat_t                 md_stat;
  logic [VALUE_WIDTH-1:0]   md_a, md_b, md_res;

  // Front end: every transfer on the input side is classified here at once.
  // Characters that are neither digits nor operators never reach the queue,
  // unless they close the expression.
  iee_front u_front (
    .push_i      (push),
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .q_full_i    (q_full),
    .full_o      (full),
    .wr_o        (q_wr),
    .tok_o       (q_wdata)
  );

  // Token queue decouples input transfers from the slow arithmetic.
  iee_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: operand/term/sum folding; the result register acts as the
  // output stage, so a new expression can proceed while a result waits.
  iee_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_i         (q_rdata),
    .tok_empty_i   (q_empty),
    .tok_pop_o     (q_rd),
    .md_ctrl_o     (md_ctrl),
    .md_a_o        (md_a),
    .md_b_o        (md_b),
    .md_res_i      (md_res),
    .md_stat_i     (md_stat),
    .pop_i         (pop),
    .empty_o       (empty),
    .value_o       (value_o),
    .div_by_zero_o (div_by_zero_o)
  );

  // One bit per cycle: shift-add multiply, restoring divide on magnitudes.
  iee_muldiv #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (md_ctrl),
    .a_i    (md_a),
    .b_i    (md_b),
    .res_o  (md_res),
    .stat_o (md_stat)
  );

endmodule

// ----- sim/infix_expression_evaluator_tb.sv -----
// Self-checking testbench: character stream stimulus against a predictor of the evaluator.
module infix_expression_evaluator_tb;
  import iee_pkg::*;

  localparam int unsigned VW          = VALUE_WIDTH_DEF;
  localparam int unsigned RAND_ITEMS  = 700;
  localparam int unsigned QUIET_FROM  = 250;
  localparam int unsigned QUIET_TO    = 420;
  localparam int unsigned DRAIN_AT    = 350;
  localparam int unsigned TAIL_CYCLES = 2 * VW + 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned N_DIRECTED  = 5;
  localparam int unsigned TEXT_CHARS  = 21;

  typedef struct packed {
    logic signed [RESULT_WIDTH-1:0] value;
    logic                           dbz;
  } result_t;

  // Directed row: text is right-aligned, first character leftmost; last goes on the final one.
  typedef struct packed {
    logic [8*TEXT_CHARS-1:0] text;
    logic [4:0]              len;
    logic                    typed;
    result_t                 res;
  } dir_row_t;

  typedef logic [7:0] chars_t [$];

  localparam logic [7:0] OPS [4] = '{CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV};

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // add and subtract, leading missing operand
    '{text: "+-5", len: 5'd3, typed: 1'b1, res: '{value: -32'sd5, dbz: 1'b0}},
    // trailing operator leaves a missing operand
    '{text: "3*", len: 5'd2, typed: 1'b1, res: '{value: 32'sd0, dbz: 1'b0}},
    // ignored extremes of the code range around 0/0
    '{text: {8'h00, CHAR_DIV, 8'hFF}, len: 5'd3, typed: 1'b1,
      res: '{value: 32'sd0, dbz: 1'b1}},
    // most negative value divided by -1 wraps
    '{text: "2147483648/4294967295", len: 5'd21, typed: 1'b1,
      res: '{value: 32'h8000_0000, dbz: 1'b0}},
    '{text: "7-8*3", len: 5'd5, typed: 1'b0, res: '0}
  };

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       pop         = 1'b0;
  logic [7:0] char_code   = 8'h00;
  logic       last        = 1'b0;
  logic       quiet       = 1'b0;
  logic       full;
  logic       empty;
  logic signed [RESULT_WIDTH-1:0] value_o;
  logic       div_by_zero_o;

  result_t     expected_results [$];
  int unsigned cycle_cnt = 0;
  int unsigned errors    = 0;

  // predictor state
  logic [VW-1:0] operand_acc = '0;
  logic [VW-1:0] term_acc    = '0;
  logic [VW-1:0] sum_acc     = '0;
  pend_e         term_op     = PEND_NONE;
  logic          term_neg    = 1'b0;
  logic          zero_div    = 1'b0;

  infix_expression_evaluator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .char_code_i  (char_code),
    .last_i       (last),
    .empty        (empty),
    .pop          (pop),
    .value_o      (value_o),
    .div_by_zero_o(div_by_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic is_digit(logic [7:0] c);
    return c >= CHAR_ZERO && c < CHAR_ZERO + RADIX;
  endfunction

  function automatic void clear_eval();
    operand_acc = '0;
    term_acc    = '0;
    sum_acc     = '0;
    term_op     = PEND_NONE;
    term_neg    = 1'b0;
    zero_div    = 1'b0;
  endfunction

  // Signed divide, truncating toward zero; a zero divisor gives 0 and sets the flag.
  function automatic logic [VW-1:0] quotient(logic [VW-1:0] a, logic [VW-1:0] b);
    logic [VW-1:0] mag_a;
    logic [VW-1:0] mag_b;
    logic [VW-1:0] q;
    mag_a = a[VW-1] ? -a : a;
    mag_b = b[VW-1] ? -b : b;
    if (mag_b == '0) begin
      zero_div = 1'b1;
      return '0;
    end
    q = mag_a / mag_b;
    return (a[VW-1] != b[VW-1]) ? -q : q;
  endfunction

  function automatic void fold_operand();
    case (term_op)
      PEND_MUL: term_acc = term_acc * operand_acc;
      PEND_DIV: term_acc = quotient(term_acc, operand_acc);
      default:  term_acc = operand_acc;
    endcase
    operand_acc = '0;
  endfunction

  function automatic void fold_term();
    sum_acc  = term_neg ? sum_acc - term_acc : sum_acc + term_acc;
    term_acc = '0;
    term_op  = PEND_NONE;
  endfunction

  // Advances the predictor by one character; returns 1 when the expression closes.
  function automatic logic eval_char(logic [7:0] c, logic fin, output result_t res);
    res = '0;
    if (is_digit(c)) begin
      operand_acc = operand_acc * RADIX + VW'(c - CHAR_ZERO);
    end else if (c == CHAR_MUL || c == CHAR_DIV) begin
      fold_operand();
      term_op = (c == CHAR_MUL) ? PEND_MUL : PEND_DIV;
    end else if (c == CHAR_ADD || c == CHAR_SUB) begin
      fold_operand();
      fold_term();
      term_neg = (c == CHAR_SUB);
    end
    if (!fin)
      return 1'b0;
    fold_operand();
    fold_term();
    res.value = sum_acc;
    res.dbz   = zero_div;
    clear_eval();
    return 1'b1;
  endfunction

  // Random operand: mostly short, some long enough to wrap, a few edge values, some missing.
  function automatic chars_t random_operand();
    chars_t        digits;
    int unsigned   pick;
    logic [VW-1:0] v;
    digits = {};
    pick   = $urandom_range(0, 99);
    if (pick < 8) begin
      digits.push_back(CHAR_ZERO);
    end else if (pick < 12) begin
      // missing operand
    end else if (pick < 18) begin
      case ($urandom_range(0, 2))
        0:       v = 32'h8000_0000;
        1:       v = 32'hFFFF_FFFF;
        default: v = 32'h7FFF_FFFF;
      endcase
      while (v != '0) begin
        digits.push_front(CHAR_ZERO + 8'(v % RADIX));
        v = v / RADIX;
      end
    end else begin
      repeat ((pick < 85) ? $urandom_range(1, 3) : $urandom_range(4, 12))
        digits.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
    return digits;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                           input result_t typed_res);
    result_t res;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    push      <= 1'b1;
    char_code <= c;
    last      <= fin;
    do @(posedge clk_i); while (full);
    if (eval_char(c, fin, res))
      expected_results.push_back(typed ? typed_res : res);
  endtask

  initial begin
    chars_t      expr;
    int unsigned counted;
    logic        drained;
    counted = 0;
    drained = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[r])
      for (int i = DIRECTED[r].len - 1; i >= 0; i--)
        send_char(DIRECTED[r].text[8*i +: 8], i == 0, DIRECTED[r].typed, DIRECTED[r].res);

    // hold off until the directed results are all back
    push <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);

    while (counted < RAND_ITEMS) begin
      expr = {};
      if ($urandom_range(0, 99) < 80) begin
        expr = random_operand();
        repeat ($urandom_range(0, 5)) begin
          expr.push_back(OPS[$urandom_range(0, 3)]);
          if ($urandom_range(0, 19) == 0)
            expr.push_back(8'($urandom_range(0, 255)));
          expr = {expr, random_operand()};
        end
      end else begin
        // broken sequences and noise
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 2))
            0:       expr.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            1:       expr.push_back(OPS[$urandom_range(0, 3)]);
            default: expr.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      if (expr.size() == 0)
        expr.push_back(8'($urandom_range(0, 255)));

      foreach (expr[i]) begin
        quiet <= (counted >= QUIET_FROM && counted < QUIET_TO);
        send_char(expr[i], i == expr.size() - 1, 1'b0, '0);
        if (i == expr.size() - 1 || is_digit(expr[i]) || expr[i] inside {OPS})
          counted++;
      end

      if (!drained && counted >= DRAIN_AT) begin
        drained = 1'b1;
        push <= 1'b0;
        do @(posedge clk_i); while (expected_results.size() != 0);
      end
    end

    push <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("infix_expression_evaluator_tb passed");
    else
      $display("infix_expression_evaluator_tb failed");
    $finish;
  end

  // Result side: random pop, compare each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    cycle_cnt++;
    pop <= rst_ni && (quiet || $urandom_range(0, 99) >= 10);
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value %0d div_by_zero %0b",
                 $time, value_o, div_by_zero_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (value_o !== want.value) begin
          $display("%0t: value expected %0d actual %0d", $time, want.value, value_o);
          errors++;
        end
        if (div_by_zero_o !== want.dbz) begin
          $display("%0t: div_by_zero expected %0b actual %0b",
                   $time, want.dbz, div_by_zero_o);
          errors++;
        end
      end
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("infix_expression_evaluator_tb failed");
      $finish;
    end
  end

endmodule
